/* hdl/lcdp_pkg.sv */
// ----------------------------------------------------------------------------
// lcdp_pkg
// Shared constants for the LED control datagram parser: parse phases,
// message types, result codes, control register indexes and field lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned SIZE_W      = 16;
   localparam int unsigned LED_W       = 16;
   localparam int unsigned LED3_W      = LED_W + 2;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned PHASE_W     = 4;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJECT_KEY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_NUMBER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT   = 2'd3;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_SRC     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_KEY     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_LEN     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_COUNT   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_TARGETS = 4'd5;
   localparam logic [PHASE_W-1:0] PH_ADDR    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_NODE    = 4'd7;
   localparam logic [PHASE_W-1:0] PH_TIME    = 4'd8;
   localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd9;

   // message types
   localparam logic [BYTE_W-1:0] MSG_TARGET1  = 8'd1;
   localparam logic [BYTE_W-1:0] MSG_TARGET2  = 8'd2;
   localparam logic [BYTE_W-1:0] MSG_SERVER   = 8'd5;
   localparam logic [BYTE_W-1:0] MSG_COMMAND  = 8'd6;
   localparam logic [BYTE_W-1:0] MSG_TIME     = 8'd7;
   localparam logic [BYTE_W-1:0] MSG_NODETIME = 8'd12;

   // result codes
   localparam logic [CODE_W-1:0] RES_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] RES_SERVER  = 3'd3;
   localparam logic [CODE_W-1:0] RES_COMMAND = 3'd4;
   localparam logic [CODE_W-1:0] RES_TIME    = 3'd5;

   // field lengths in bytes
   localparam logic [BYTE_W-1:0] KEY_BYTES  = 8'd4;
   localparam logic [BYTE_W-1:0] LEN_BYTES  = 8'd2;
   localparam logic [BYTE_W-1:0] WORD_BYTES = 8'd4;

endpackage

`default_nettype wire

/* hdl/led_control_datagram_parser.sv */
// ----------------------------------------------------------------------------
// led_control_datagram_parser
// Parses one LED control datagram per frame, one byte per transfer, and
// gives one result transfer for the last byte of each frame.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                        | side band
//  req_     | in        | [7:0] data_byte              | tlast = last_byte
//  rsp_     | out       | [31:0] server_addr,          | tuser[2:0] = result_code
//           |           | [63:32] time_value           |
//  csr_     | in        | csr_wdata, index 0..3        | write only, no wait
//
//  One byte is taken every cycle while the result path moves. The parse
//  state updates in the cycle a byte is taken; a last byte loads a middle
//  register, whose time value goes through the 32x18 scale multiplier into
//  the result register. Reset is synchronous and clears all control and
//  configuration state. A stalled result holds the middle register, then
//  stops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module led_control_datagram_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [31:0] server_addr, [63:32] time_value
   output logic [2:0]   rsp_tuser,   // [2:0] result_code
   input  logic         csr_we,
   input  logic [lcdp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lcdp_pkg::WORD_W-1:0]    csr_wdata
);

   import lcdp_pkg::*;

   // configuration
   logic [SIZE_W-1:0]  packet_size_ff;
   logic [WORD_W-1:0]  project_key_ff;
   logic [BYTE_W-1:0]  node_number_ff;
   logic [LED3_W-1:0]  led3_ff;
   logic [LED3_W-1:0]  led3_in;

   // parse state
   logic [SIZE_W-1:0]  byte_pos_ff, byte_pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  msg_type_ff, msg_type_in;
   logic [BYTE_W-1:0]  left_ff, left_in;
   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [CODE_W-1:0]  pend_ff, pend_in;
   logic [WORD_W-1:0]  addr_ff, addr_in;
   logic [WORD_W-1:0]  time_ff, time_in;

   // middle and result stages
   logic               mid_valid_ff;
   logic [CODE_W-1:0]  mid_code_ff;
   logic [WORD_W-1:0]  mid_addr_ff;
   logic [WORD_W-1:0]  mid_time_ff;
   logic               out_valid_ff;
   logic [CODE_W-1:0]  out_code_ff;
   logic [WORD_W-1:0]  out_addr_ff;
   logic [WORD_W-1:0]  out_time_ff;

   logic               mid_move;
   logic               take;
   logic [WORD_W-1:0]  shift_byte;
   logic [BYTE_W-1:0]  left_dec;
   logic               field_done;
   logic [SIZE_W:0]    pos_plus;
   logic               len_ok;
   logic [CODE_W-1:0]  fin_code;
   logic [WORD_W+LED3_W-1:0] product;

   assign mid_move   = !out_valid_ff || rsp_tready;
   assign req_tready = !mid_valid_ff || mid_move;
   assign take       = req_tvalid && req_tready;

   assign led3_in = {2'b00, csr_wdata[LED_W-1:0]} + {1'b0, csr_wdata[LED_W-1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_size_ff <= '0;
         project_key_ff <= '0;
         node_number_ff <= '0;
         led3_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PACKET_SIZE: packet_size_ff <= csr_wdata[SIZE_W-1:0];
            CSR_PROJECT_KEY: project_key_ff <= csr_wdata;
            CSR_NODE_NUMBER: node_number_ff <= csr_wdata[BYTE_W-1:0];
            CSR_LED_COUNT:   led3_ff        <= led3_in;
            default: ;
         endcase
      end
   end

   // one byte of a multi-byte field
   assign shift_byte = {shift_ff[WORD_W-BYTE_W-1:0], req_tdata};
   assign left_dec   = (left_ff != '0) ? left_ff - 8'd1 : '0;
   assign field_done = (left_dec == '0);

   always_comb begin
      phase_in    = phase_ff;
      msg_type_in = msg_type_ff;
      left_in     = left_ff;
      shift_in    = shift_ff;
      pend_in     = pend_ff;
      addr_in     = addr_ff;
      time_in     = time_ff;
      unique case (phase_ff)
         PH_SRC: begin
            if (req_tdata == '0) begin
               phase_in = PH_KEY;
               shift_in = '0;
               left_in  = KEY_BYTES;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_KEY: begin
            shift_in = shift_byte;
            left_in  = left_dec;
            if (field_done)
               phase_in = (shift_byte == project_key_ff) ? PH_TYPE : PH_IDLE;
         end
         PH_TYPE: begin
            msg_type_in = req_tdata;
            if (req_tdata == MSG_TARGET1 || req_tdata == MSG_TARGET2 ||
                req_tdata == MSG_SERVER || req_tdata == MSG_TIME ||
                req_tdata == MSG_NODETIME) begin
               phase_in = PH_LEN;
               shift_in = '0;
               left_in  = LEN_BYTES;
            end else if (req_tdata == MSG_COMMAND) begin
               pend_in  = RES_COMMAND;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_LEN: begin
            shift_in = shift_byte;
            left_in  = left_dec;
            if (field_done) begin
               priority if (msg_type_ff == MSG_TARGET1 || msg_type_ff == MSG_TARGET2) begin
                  phase_in = PH_COUNT;
               end else if (msg_type_ff == MSG_SERVER) begin
                  phase_in = PH_ADDR;
                  shift_in = '0;
                  left_in  = WORD_BYTES;
               end else if (msg_type_ff == MSG_TIME) begin
                  phase_in = PH_TIME;
                  shift_in = '0;
                  left_in  = WORD_BYTES;
               end else begin
                  phase_in = PH_NODE;
               end
            end
         end
         PH_COUNT: begin
            if (req_tdata == '0) begin
               // empty list addresses every node
               pend_in  = msg_type_ff[CODE_W-1:0];
               phase_in = PH_IDLE;
            end else begin
               left_in  = req_tdata;
               phase_in = PH_TARGETS;
            end
         end
         PH_TARGETS: begin
            if (req_tdata == node_number_ff) begin
               pend_in  = msg_type_ff[CODE_W-1:0];
               phase_in = PH_IDLE;
            end else begin
               left_in = left_dec;
               if (field_done)
                  phase_in = PH_IDLE;
            end
         end
         PH_ADDR: begin
            shift_in = shift_byte;
            left_in  = left_dec;
            if (field_done) begin
               addr_in  = shift_byte;
               pend_in  = RES_SERVER;
               phase_in = PH_IDLE;
            end
         end
         PH_NODE: begin
            if (req_tdata == node_number_ff) begin
               phase_in = PH_TIME;
               shift_in = '0;
               left_in  = WORD_BYTES;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_TIME: begin
            shift_in = shift_byte;
            left_in  = left_dec;
            if (field_done) begin
               // hold the raw time, scale it on the way out
               time_in  = shift_byte;
               pend_in  = RES_TIME;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // length check at the last byte
   assign pos_plus = {1'b0, byte_pos_ff} + 17'd1;
   assign len_ok   = (byte_pos_ff != '1) && (pos_plus == {1'b0, packet_size_ff});
   assign fin_code = len_ok ? pend_in : RES_NONE;
   assign byte_pos_in = (byte_pos_ff != '1) ? byte_pos_ff + 16'd1 : byte_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         phase_ff    <= PH_SRC;
         msg_type_ff <= '0;
         left_ff     <= '0;
         shift_ff    <= '0;
         pend_ff     <= RES_NONE;
         addr_ff     <= '0;
         time_ff     <= '0;
      end else if (take) begin
         if (req_tlast) begin
            // start a new datagram
            byte_pos_ff <= '0;
            phase_ff    <= PH_SRC;
            msg_type_ff <= '0;
            left_ff     <= '0;
            shift_ff    <= '0;
            pend_ff     <= RES_NONE;
            addr_ff     <= '0;
            time_ff     <= '0;
         end else begin
            byte_pos_ff <= byte_pos_in;
            phase_ff    <= phase_in;
            msg_type_ff <= msg_type_in;
            left_ff     <= left_in;
            shift_ff    <= shift_in;
            pend_ff     <= pend_in;
            addr_ff     <= addr_in;
            time_ff     <= time_in;
         end
      end
   end

   // middle stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (req_tready) begin
         mid_valid_ff <= take && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_tlast) begin
         mid_code_ff <= fin_code;
         mid_addr_ff <= (fin_code == RES_SERVER) ? addr_in : '0;
         mid_time_ff <= (fin_code == RES_TIME) ? time_in : '0;
      end
   end

   assign product = mid_time_ff * led3_ff;

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (mid_move) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_move && mid_valid_ff) begin
         out_code_ff <= mid_code_ff;
         out_addr_ff <= mid_addr_ff;
         out_time_ff <= product[WORD_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_code_ff;
   assign rsp_tdata  = {out_time_ff, out_addr_ff};

endmodule

`default_nettype wire

/* tb/led_control_datagram_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_control_datagram_parser_test
// Streams LED control datagrams into the parser, one byte per transfer, and
// checks every result transfer against a byte-level model of the parser kept
// in this bench. Runs several register settings, random idling on both sides,
// one long result stall and frames of wrong length.
// ----------------------------------------------------------------------------

module led_control_datagram_parser_test;
   import lcdp_pkg::*;

   typedef logic [BYTE_W-1:0] frame_type[$];

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_byte_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] server;
      logic [WORD_W-1:0] stamp;
   } parse_result_type;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic [2:0]           rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_wdata  = '0;

   // register copies
   logic [SIZE_W-1:0]    size_reg   = '0;
   logic [WORD_W-1:0]    key_reg    = '0;
   logic [BYTE_W-1:0]    node_reg   = '0;
   logic [LED_W-1:0]     leds_reg   = '0;

   // datagram parse state
   logic [SIZE_W-1:0]    frame_pos  = '0;
   logic [PHASE_W-1:0]   phase      = PH_SRC;
   logic [BYTE_W-1:0]    msg_type   = '0;
   logic [BYTE_W-1:0]    bytes_left = '0;
   logic [WORD_W-1:0]    field_acc  = '0;
   logic [CODE_W-1:0]    code_acc   = RES_NONE;
   logic [WORD_W-1:0]    server_acc = '0;
   logic [WORD_W-1:0]    stamp_acc  = '0;

   frame_byte_type       pending_bytes[$];
   parse_result_type     expected_results[$];

   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   bit                   backpressure_armed = 1'b0;
   bit                   hold_done = 1'b0;
   int unsigned          hold_left = 0;
   int unsigned          errors = 0;
   int unsigned          quiet_cycles = 0;

   led_control_datagram_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] server_addr, [63:32] time_value
      .rsp_tuser  (rsp_tuser),    // [2:0] result_code
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [BYTE_W-1:0] any_byte();
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic bit shift_in(input logic [BYTE_W-1:0] b);
      field_acc = {field_acc[23:0], b};
      if (bytes_left != 0)
         bytes_left--;
      return bytes_left == 0;
   endfunction

   function automatic void open_field(input logic [PHASE_W-1:0] ph,
                                      input logic [BYTE_W-1:0] n);
      phase = ph;
      field_acc = '0;
      bytes_left = n;
   endfunction

   // Advance the parse state by one byte; queue the result on a last byte.
   task automatic parse_datagram_byte(input logic [BYTE_W-1:0] b, input logic last);
      parse_result_type res;
      case (phase)
         PH_SRC: begin
            if (b == 8'd0)
               open_field(PH_KEY, KEY_BYTES);
            else
               phase = PH_IDLE;
         end
         PH_KEY: begin
            if (shift_in(b))
               phase = (field_acc == key_reg) ? PH_TYPE : PH_IDLE;
         end
         PH_TYPE: begin
            msg_type = b;
            if (b == MSG_TARGET1 || b == MSG_TARGET2 || b == MSG_SERVER ||
                b == MSG_TIME || b == MSG_NODETIME) begin
               open_field(PH_LEN, LEN_BYTES);
            end else if (b == MSG_COMMAND) begin
               code_acc = RES_COMMAND;
               phase = PH_IDLE;
            end else begin
               phase = PH_IDLE;
            end
         end
         PH_LEN: begin
            if (shift_in(b)) begin
               if (msg_type == MSG_TARGET1 || msg_type == MSG_TARGET2)
                  phase = PH_COUNT;
               else if (msg_type == MSG_SERVER)
                  open_field(PH_ADDR, WORD_BYTES);
               else if (msg_type == MSG_TIME)
                  open_field(PH_TIME, WORD_BYTES);
               else
                  phase = PH_NODE;
            end
         end
         PH_COUNT: begin
            // an empty target list addresses every node
            if (b == 8'd0) begin
               code_acc = msg_type[CODE_W-1:0];
               phase = PH_IDLE;
            end else begin
               bytes_left = b;
               phase = PH_TARGETS;
            end
         end
         PH_TARGETS: begin
            if (b == node_reg) begin
               code_acc = msg_type[CODE_W-1:0];
               phase = PH_IDLE;
            end else begin
               if (bytes_left != 0)
                  bytes_left--;
               if (bytes_left == 0)
                  phase = PH_IDLE;
            end
         end
         PH_ADDR: begin
            if (shift_in(b)) begin
               server_acc = field_acc;
               code_acc = RES_SERVER;
               phase = PH_IDLE;
            end
         end
         PH_NODE: begin
            if (b == node_reg)
               open_field(PH_TIME, WORD_BYTES);
            else
               phase = PH_IDLE;
         end
         PH_TIME: begin
            if (shift_in(b)) begin
               stamp_acc = field_acc * ({16'd0, leds_reg} * 32'd3);
               code_acc = RES_TIME;
               phase = PH_IDLE;
            end
         end
         default: phase = PH_IDLE;
      endcase

      if (!last) begin
         if (frame_pos != 16'hFFFF)
            frame_pos++;
      end else begin
         res.code = RES_NONE;
         if (frame_pos != 16'hFFFF && {1'b0, frame_pos} + 17'd1 == {1'b0, size_reg})
            res.code = code_acc;
         res.server = (res.code == RES_SERVER) ? server_acc : '0;
         res.stamp  = (res.code == RES_TIME) ? stamp_acc : '0;
         expected_results.push_back(res);
         frame_pos = '0;
         phase = PH_SRC;
         msg_type = '0;
         bytes_left = '0;
         field_acc = '0;
         code_acc = RES_NONE;
         server_acc = '0;
         stamp_acc = '0;
      end
   endtask

   always @(posedge clock) begin : drive_req
      frame_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            parse_datagram_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      parse_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result transfer with none expected: code %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.code) begin
                  $display("%0t: result_code expected %0d actual %0d",
                           $time, want.code, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[31:0] !== want.server) begin
                  $display("%0t: server_addr expected %h actual %h",
                           $time, want.server, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== want.stamp) begin
                  $display("%0t: time_value expected %h actual %h",
                           $time, want.stamp, rsp_tdata[63:32]);
                  errors++;
               end
            end
         end
         // one long hold so the parser fills up and stops taking bytes
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (backpressure_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PACKET_SIZE: size_reg = value[SIZE_W-1:0];
         CSR_PROJECT_KEY: key_reg  = value;
         CSR_NODE_NUMBER: node_reg = value[BYTE_W-1:0];
         CSR_LED_COUNT:   leds_reg = value[LED_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [WORD_W-1:0] size_v, input logic [WORD_W-1:0] key_v,
                            input logic [WORD_W-1:0] node_v, input logic [WORD_W-1:0] leds_v);
      write_reg(CSR_PACKET_SIZE, size_v);
      write_reg(CSR_PROJECT_KEY, key_v);
      write_reg(CSR_NODE_NUMBER, node_v);
      write_reg(CSR_LED_COUNT, leds_v);
   endtask

   // Wait until every byte is taken and every result has come, then let the
   // result pipeline settle.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_frame(input frame_type f);
      frame_byte_type fb;
      for (int i = 0; i < f.size(); i++) begin
         fb.data = f[i];
         fb.last = (i == f.size() - 1);
         pending_bytes.push_back(fb);
      end
   endtask

   task automatic fit_length(inout frame_type f, input int unsigned len);
      while (f.size() > len)
         void'(f.pop_back());
      while (f.size() < len)
         f.push_back(any_byte());
   endtask

   // hit: 0 another node, 1 this node, 2 all nodes
   task automatic build_frame(output frame_type f, input logic [BYTE_W-1:0] mtype,
                              input int unsigned hit);
      int unsigned count;
      int unsigned spot;
      logic [BYTE_W-1:0] b;
      f = {8'h00, key_reg[31:24], key_reg[23:16], key_reg[15:8], key_reg[7:0], mtype};
      if (mtype == MSG_COMMAND)
         return;
      f.push_back(any_byte());
      f.push_back(any_byte());
      if (mtype == MSG_TARGET1 || mtype == MSG_TARGET2) begin
         if (hit == 2) begin
            f.push_back(8'd0);
         end else begin
            count = $urandom_range(1, 6);
            spot = $urandom_range(0, count - 1);
            f.push_back(BYTE_W'(count));
            for (int i = 0; i < count; i++) begin
               b = any_byte();
               if (hit == 1 && i == spot)
                  b = node_reg;
               else if (hit == 0 && b == node_reg)
                  b = node_reg ^ 8'h01;
               f.push_back(b);
            end
         end
      end else if (mtype == MSG_NODETIME) begin
         f.push_back(hit == 0 ? node_reg ^ 8'h10 : node_reg);
         repeat (4) f.push_back(any_byte());
      end else if (mtype == MSG_SERVER || mtype == MSG_TIME) begin
         repeat (4) f.push_back(any_byte());
      end
   endtask

   task automatic random_frame(output frame_type f);
      logic [BYTE_W-1:0] kinds[6];
      logic [BYTE_W-1:0] mtype;
      int unsigned pick;
      int unsigned len;
      kinds = '{MSG_TARGET1, MSG_TARGET2, MSG_SERVER, MSG_COMMAND, MSG_TIME, MSG_NODETIME};
      pick = $urandom_range(99);
      if (pick < 75) begin
         build_frame(f, kinds[$urandom_range(5)], $urandom_range(3) == 0 ? 0 :
                     ($urandom_range(3) == 0 ? 2 : 1));
         if ($urandom_range(9) == 0)
            f[$urandom_range(1, 4)] ^= BYTE_W'(1 << $urandom_range(7));
      end else if (pick < 85) begin
         do
            mtype = any_byte();
         while (mtype == MSG_TARGET1 || mtype == MSG_TARGET2 || mtype == MSG_SERVER ||
                mtype == MSG_COMMAND || mtype == MSG_TIME || mtype == MSG_NODETIME);
         build_frame(f, MSG_COMMAND, 1);
         f[5] = mtype;
      end else if (pick < 92) begin
         build_frame(f, kinds[$urandom_range(5)], 1);
         f[0] = BYTE_W'($urandom_range(1, 255));
      end else begin
         f = {};
         repeat ($urandom_range(1, 24)) f.push_back(any_byte());
      end

      pick = $urandom_range(99);
      if (size_reg == 0)
         len = f.size() + $urandom_range(0, 3);
      else if (pick < 80)
         len = size_reg;
      else if (pick < 90)
         len = size_reg + $urandom_range(0, 2) - 1;
      else
         len = $urandom_range(1, f.size());
      if (len == 0)
         len = 1;
      fit_length(f, len);
   endtask

   task automatic run_random(input int unsigned items);
      frame_type f;
      int unsigned sent;
      sent = 0;
      while (sent < items) begin
         random_frame(f);
         queue_frame(f);
         sent += f.size();
      end
   endtask

   initial begin
      frame_type f;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      send_idle_pct = 20;
      recv_idle_pct = 58;
      configure(16, 32'h0000_0000, 0, 16'hFFFF);

      build_frame(f, MSG_TARGET1, 1);  fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_TARGET2, 1);  fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_SERVER, 1);   fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_COMMAND, 1);  fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_TIME, 1);     fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_NODETIME, 1); fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_TARGET1, 2);  fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_TARGET2, 0);  fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_NODETIME, 0); fit_length(f, 16); queue_frame(f);
      // all-ones time field at the largest LED count
      build_frame(f, MSG_TIME, 1);
      for (int i = 8; i < 12; i++)
         f[i] = 8'hFF;
      fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_COMMAND, 1); f[5] = 8'h00; fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_COMMAND, 1); f[5] = 8'hFF; fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_TIME, 1);    f[0] = 8'h80; fit_length(f, 16); queue_frame(f);
      build_frame(f, MSG_SERVER, 1);  f[4] ^= 8'h01; fit_length(f, 16); queue_frame(f);
      // ends inside the time field
      build_frame(f, MSG_TIME, 1);    fit_length(f, 10); queue_frame(f);
      build_frame(f, MSG_COMMAND, 1); fit_length(f, 17); queue_frame(f);
      build_frame(f, MSG_COMMAND, 1); fit_length(f, 1);  queue_frame(f);
      run_random(140);
      wait_idle();

      configure(20, 32'hFFFF_FFFF, 255, 0);
      run_random(140);
      wait_idle();

      // receiver idles lightly, sender heavily, with one long result stall
      send_idle_pct = 58;
      recv_idle_pct = 20;
      configure($urandom_range(16, 24), $urandom, $urandom_range(255), $urandom_range(65535));
      run_random(140);
      backpressure_armed = 1'b1;
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // a zero length never matches
      configure(0, $urandom, $urandom_range(255), $urandom_range(65535));
      run_random(50);
      wait_idle();

      configure($urandom_range(16, 24), $urandom, $urandom_range(255), $urandom_range(65535));
      run_random(80);
      wait_idle();

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
